>>> hw/rtl/bitmap_set_clear_count_find_first_defines.svh
// assertion macros used by the bitmap top level
`ifndef BITMAP_SET_CLEAR_COUNT_FIND_FIRST_DEFINES_SVH
`define BITMAP_SET_CLEAR_COUNT_FIND_FIRST_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BSCF_ASSERT_IMM(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap check failed");

// next-cycle implication, checked out of reset
`define BSCF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitmap check failed");

`endif

>>> hw/rtl/bscf_pkg.sv
// shared types and constants of the bitmap block
package bscf_pkg;

  localparam int unsigned POS_W = 10;
  localparam int unsigned CNT_W = 11;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_READ  = 2'd0;
  localparam opcode_t OP_SET   = 2'd1;
  localparam opcode_t OP_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_MOD,
    ST_SCAN,
    ST_FIND,
    ST_DONE
  } state_e;

endpackage

>>> hw/rtl/bscf_store.sv
// single-port word store of the bit map, registered read
module bscf_store #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned AW        = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        addr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bscf_ffs.sv
// two-stage lowest-set-bit finder for one stored word
module bscf_ffs #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned AW        = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [WORD_BITS-1:0]        word_i,
  input  logic [AW-1:0]               index_i,
  output logic                        done_o,
  output logic [bscf_pkg::POS_W-1:0]  first_o
);
  import bscf_pkg::*;

  localparam int unsigned BW = $clog2(WORD_BITS);
  localparam int unsigned PW = AW + POS_W;

  logic [BW-1:0]    low_idx;
  logic [PW-1:0]    base_prod;
  logic [BW-1:0]    low_q;
  logic [POS_W-1:0] base_q;
  logic [POS_W-1:0] first_q;
  logic             v1_q;
  logic             v2_q;

  // lowest one wins
  always_comb begin
    low_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        low_idx = BW'(i);
      end
    end
  end

  assign base_prod = PW'(index_i) * PW'(WORD_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      low_q  <= low_idx;
      base_q <= base_prod[POS_W-1:0];
    end
    if (v1_q) begin
      first_q <= base_q + POS_W'(low_q);
    end
  end

  assign done_o  = v2_q;
  assign first_o = first_q;

endmodule

>>> hw/rtl/bitmap_set_clear_count_find_first.sv
// top level of the bit map with set, clear, population count and find-first
//
// input channel: one word per item, opcode_i (read, set, clear; the spare code
// reads) and position_i. output channel: one word per item with the addressed
// bit after the operation, the count of ones in the map, the lowest set
// position and an empty flag (first_set_o is zero when the map is empty).
// the map lives in one single-port ram of BITS/WORD_BITS words, rounded up;
// positions at or beyond BITS leave the map alone and report bit zero.
// an item passes ST_DIV, ST_ADDR (ram read) and ST_MOD (write-back); unless
// the map ends up empty it then scans in ST_SCAN for the first non-zero word
// and finds its lowest bit in ST_FIND; the word scan reads one ram word per cycle.
// items are taken one at a time: the next can be accepted in the cycle after
// the previous result is loaded. after reset a clearing pass writes zero to
// every ram word, one per cycle, with in_ready_o low.
// the result sits in an output register: a stalled receiver does not stop
// the next item being accepted and worked on; only its final load waits
`include "bitmap_set_clear_count_find_first_defines.svh"

module bitmap_set_clear_count_find_first #(
  parameter int unsigned BITS      = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bscf_pkg::opcode_t           opcode_i,
  input  logic [bscf_pkg::POS_W-1:0]  position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        bit_value_o,
  output logic [bscf_pkg::CNT_W-1:0]  ones_count_o,
  output logic [bscf_pkg::POS_W-1:0]  first_set_o,
  output logic                        map_empty_o
);
  import bscf_pkg::*;

  // map geometry
  localparam int unsigned NWORDS = (BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned BW     = $clog2(WORD_BITS);
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

  // word index by reciprocal multiply, exact for any 10-bit position
  localparam int unsigned DIV_S = 20;
  localparam int unsigned DIV_M = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned MW    = 21;
  localparam int unsigned PW    = POS_W + MW + AW;
  localparam int unsigned RW    = POS_W + AW;
  localparam int unsigned BCW   = 17;
  localparam logic [BCW-1:0] BITS_C = BCW'(BITS);

  // control state
  state_e           state_q, state_d;
  logic [AW-1:0]    ptr_q, ptr_d;       // clear pass and scan address
  logic [AW-1:0]    idx_q, idx_d;       // address of the scan read in flight
  logic             pend_q, pend_d;     // scan read in flight
  logic [CNT_W-1:0] ones_q, ones_d;
  logic             out_valid_q, out_valid_d;

  // item payload
  opcode_t          op_q;
  logic [POS_W-1:0] pos_q;
  logic [AW-1:0]    wi_q, wi_d;
  logic [BW-1:0]    bi_q, bi_d;
  logic             inr_q, inr_d;

  // pending result
  logic             res_bit_q, res_bit_d;
  logic [POS_W-1:0] res_first_q, res_first_d;
  logic             res_empty_q, res_empty_d;
  logic [CNT_W-1:0] res_ones_q, res_ones_d;

  // output word
  logic             out_bit_q;
  logic [CNT_W-1:0] out_ones_q;
  logic [POS_W-1:0] out_first_q;
  logic             out_empty_q;

  // ram port
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  // first-set unit
  logic             ffs_start;
  logic             ffs_done;
  logic [POS_W-1:0] ffs_first;

  // read-modify-write terms
  logic [PW-1:0]        div_prod;
  logic [RW-1:0]        wi_mul;
  logic [RW-1:0]        rem_full;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 was_set;
  logic                 do_set;
  logic                 do_clr;
  logic [WORD_BITS-1:0] new_word;
  logic [CNT_W-1:0]     ones_upd;
  logic                 scan_hit;
  logic                 out_load;

  bscf_store #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (NWORDS),
    .AW        (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  bscf_ffs #(
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_ffs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ffs_start),
    .word_i  (mem_rdata),
    .index_i (idx_q),
    .done_o  (ffs_done),
    .first_o (ffs_first)
  );

  // arithmetic shared by the states
  assign div_prod = PW'(pos_q) * PW'(DIV_M);
  assign wi_mul   = RW'(wi_q) * RW'(WORD_BITS);
  assign rem_full = RW'(pos_q) - wi_mul;

  assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bi_q;
  assign was_set  = |(mem_rdata & bit_mask);
  assign do_set   = inr_q && (op_q == OP_SET) && !was_set;
  assign do_clr   = inr_q && (op_q == OP_CLEAR) && was_set;

  always_comb begin
    new_word = mem_rdata;
    ones_upd = ones_q;
    if (do_set) begin
      new_word = mem_rdata | bit_mask;
      ones_upd = ones_q + CNT_W'(1);
    end else if (do_clr) begin
      new_word = mem_rdata & ~bit_mask;
      ones_upd = ones_q - CNT_W'(1);
    end
  end

  // scan stops on the first non-zero word coming back from the ram
  assign scan_hit = pend_q && (mem_rdata != '0);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (ptr_q == LAST_WORD) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIV;
      end
      ST_DIV:  state_d = ST_ADDR;
      ST_ADDR: state_d = ST_MOD;
      ST_MOD: begin
        state_d = (ones_upd == '0) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit) state_d = ST_FIND;
      end
      ST_FIND: begin
        if (ffs_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = ptr_q;
    mem_wdata   = '0;
    ffs_start   = 1'b0;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    ones_d      = ones_q;
    wi_d        = wi_q;
    bi_d        = bi_q;
    inr_d       = inr_q;
    res_bit_d   = res_bit_q;
    res_first_d = res_first_q;
    res_empty_d = res_empty_q;
    res_ones_d  = res_ones_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + AW'(1);
      end
      ST_IDLE: begin
      end
      ST_DIV: begin
        wi_d  = div_prod[DIV_S +: AW];
        inr_d = {{(BCW-POS_W){1'b0}}, pos_q} < BITS_C;
      end
      ST_ADDR: begin
        bi_d     = rem_full[BW-1:0];
        mem_re   = inr_q;
        mem_addr = wi_q;
      end
      ST_MOD: begin
        mem_we     = do_set || do_clr;
        mem_addr   = wi_q;
        mem_wdata  = new_word;
        ones_d     = ones_upd;
        res_ones_d = ones_upd;
        res_bit_d  = inr_q && |(new_word & bit_mask);
        ptr_d      = '0;
        pend_d     = 1'b0;
        if (ones_upd == '0) begin
          res_first_d = '0;
          res_empty_d = 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          ffs_start = 1'b1;
          pend_d    = 1'b0;
        end else begin
          mem_re = 1'b1;
          idx_d  = ptr_q;
          ptr_d  = ptr_q + AW'(1);
          pend_d = 1'b1;
        end
      end
      ST_FIND: begin
        if (ffs_done) begin
          res_first_d = ffs_first;
          res_empty_d = 1'b0;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      ones_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      ones_q      <= ones_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= opcode_i;
      pos_q <= position_i;
    end
    idx_q       <= idx_d;
    wi_q        <= wi_d;
    bi_q        <= bi_d;
    inr_q       <= inr_d;
    res_bit_q   <= res_bit_d;
    res_first_q <= res_first_d;
    res_empty_q <= res_empty_d;
    res_ones_q  <= res_ones_d;
    if (out_load) begin
      out_bit_q   <= res_bit_q;
      out_ones_q  <= res_ones_q;
      out_first_q <= res_first_q;
      out_empty_q <= res_empty_q;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign bit_value_o  = out_bit_q;
  assign ones_count_o = out_ones_q;
  assign first_set_o  = out_first_q;
  assign map_empty_o  = out_empty_q;

  // running count never exceeds the reachable positions
  `BSCF_ASSERT_IMM(a_count_range, 1'b1, ones_q <= CNT_W'(1024))
  // empty flag agrees with the count in every delivered word
  `BSCF_ASSERT_IMM(a_empty_count, out_valid_q, out_empty_q == (out_ones_q == '0))
  // an empty map reports position zero
  `BSCF_ASSERT_IMM(a_empty_first, out_valid_q && out_empty_q, out_first_q == '0)
  // one item at a time
  `BSCF_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o)
  // ram written only by the clearing pass or the write-back
  `BSCF_ASSERT_IMM(a_write_state, mem_we, state_q == ST_CLEAR || state_q == ST_MOD)

endmodule

>>> bench/bitmap_set_clear_count_find_first_tb.sv
// self-checking bench for the bit map with set, clear, count and find-first
module bitmap_set_clear_count_find_first_tb;
  import bscf_pkg::*;

  localparam int unsigned BITS        = 1024;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned NWORDS      = (BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned NUM_WORDS   = 1600;
  // the spare opcode is not in the package; the block treats it as a read
  localparam opcode_t     OP_SPARE    = 2'd3;
  // long receiver hold-off, started once after this many results
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_LEN    = 400;
  // quiet cycles allowed: hold-off plus clearing pass, slowest item and stalls
  localparam int unsigned QUIET_LIMIT = 4 * (HOLD_LEN + NWORDS + NWORDS + 8 + 16);
  localparam int unsigned DRAIN_WAIT  = 4 * (NWORDS + 8);

  typedef struct packed {
    opcode_t              op;
    logic [POS_W-1:0]     pos;
  } bitmap_req_t;

  typedef struct packed {
    logic                 bit_value;
    logic [CNT_W-1:0]     ones_count;
    logic [POS_W-1:0]     first_set;
    logic                 map_empty;
  } bitmap_result_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  opcode_t              opcode_i     = OP_READ;
  logic [POS_W-1:0]     position_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic                 bit_value_o;
  logic [CNT_W-1:0]     ones_count_o;
  logic [POS_W-1:0]     first_set_o;
  logic                 map_empty_o;

  // words still to be offered, and the answers the block owes us
  bitmap_req_t          pending_words_q[$];
  bitmap_result_t       owed_results_q[$];

  // predicted map contents and population count
  bit                   map_bits[BITS];
  logic [CNT_W-1:0]     map_ones;

  // shadow of the map at generation time, used to empty it between episodes
  bit                   gen_bits[BITS];

  int unsigned          words_sent;
  int unsigned          results_seen;
  int unsigned          mismatches;
  int unsigned          send_wait;
  int unsigned          recv_wait;
  int unsigned          hold_cnt;
  int unsigned          quiet_cycles;
  bit                   send_steady;
  bit                   recv_steady;
  bit                   hold_done;

  bitmap_set_clear_count_find_first #(
    .BITS      (BITS),
    .WORD_BITS (WORD_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bit_value_o  (bit_value_o),
    .ones_count_o (ones_count_o),
    .first_set_o  (first_set_o),
    .map_empty_o  (map_empty_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // apply one operation to the predicted map and queue the answer it owes:
  // the spare opcode reads, setting a set bit or clearing a clear one is a
  // no-op, and positions past the map leave it alone and read as zero
  task automatic apply_map_op(input opcode_t op, input logic [POS_W-1:0] pos);
    bitmap_result_t r;
    r = '0;
    r.map_empty = 1'b1;
    if (pos < BITS) begin
      if (op == OP_SET && !map_bits[pos]) begin
        map_bits[pos] = 1'b1;
        map_ones      = map_ones + 1'b1;
      end else if (op == OP_CLEAR && map_bits[pos]) begin
        map_bits[pos] = 1'b0;
        map_ones      = map_ones - 1'b1;
      end
      r.bit_value = map_bits[pos];
    end
    r.ones_count = map_ones;
    // lowest set position; stays zero with the empty flag up when none
    for (int i = 0; i < BITS; i++) begin
      if (map_bits[i] && r.map_empty) begin
        r.first_set = i[POS_W-1:0];
        r.map_empty = 1'b0;
      end
    end
    owed_results_q.push_back(r);
  endtask

  task automatic queue_word(input opcode_t op, input logic [POS_W-1:0] pos);
    bitmap_req_t w;
    w.op  = op;
    w.pos = pos;
    pending_words_q.push_back(w);
    if (pos < BITS) begin
      if (op == OP_SET) gen_bits[pos] = 1'b1;
      else if (op == OP_CLEAR) gen_bits[pos] = 1'b0;
    end
  endtask

  // stimulus generation, then reset, then the drain and the verdict
  initial begin
    int unsigned base_word;
    int unsigned ep_len;
    int unsigned pick;
    logic [POS_W-1:0] pool[6];
    logic [POS_W-1:0] pos;
    opcode_t op;

    map_ones = '0;

    // directed: empty map reads, the spare opcode, no-op set and clear,
    // first set bit in the top word, the bottom word and in between
    queue_word(OP_READ,  10'd0);
    queue_word(OP_READ,  10'd1023);
    queue_word(OP_SPARE, 10'd512);
    queue_word(OP_CLEAR, 10'd5);
    queue_word(OP_SET,   10'd1023);
    queue_word(OP_SPARE, 10'd1023);
    queue_word(OP_SET,   10'd1023);
    queue_word(OP_SET,   10'd640);
    queue_word(OP_SET,   10'd63);
    queue_word(OP_SET,   10'd0);
    queue_word(OP_READ,  10'd700);
    queue_word(OP_SPARE, 10'd0);
    queue_word(OP_CLEAR, 10'd0);
    queue_word(OP_CLEAR, 10'd0);
    queue_word(OP_CLEAR, 10'd63);
    queue_word(OP_SET,   10'd64);
    queue_word(OP_CLEAR, 10'd640);
    queue_word(OP_CLEAR, 10'd64);
    queue_word(OP_CLEAR, 10'd1023);
    queue_word(OP_SET,   10'd511);
    queue_word(OP_SET,   10'd512);
    queue_word(OP_CLEAR, 10'd511);
    queue_word(OP_CLEAR, 10'd512);
    queue_word(OP_READ,  10'd1023);

    // random: episodes that work a small pool of positions at or above some
    // word, so the first set bit lands in every word, mixed with stray
    // positions; most episodes end by clearing the whole map again
    while (pending_words_q.size() < NUM_WORDS) begin
      base_word = $urandom_range(0, NWORDS - 1);
      for (int k = 0; k < 6; k++) begin
        pool[k] = POS_W'($urandom_range(base_word * WORD_BITS, BITS - 1));
      end
      ep_len = $urandom_range(10, 60);
      for (int n = 0; n < ep_len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) op = OP_SET;
        else if (pick < 80) op = OP_CLEAR;
        else if (pick < 94) op = OP_READ;
        else op = OP_SPARE;
        if ($urandom_range(0, 99) < 85) pos = pool[$urandom_range(0, 5)];
        else pos = POS_W'($urandom_range(0, BITS - 1));
        queue_word(op, pos);
      end
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1) != 0) begin
          for (int i = 0; i < BITS; i++) begin
            if (gen_bits[i]) queue_word(OP_CLEAR, i[POS_W-1:0]);
          end
        end else begin
          for (int i = BITS - 1; i >= 0; i--) begin
            if (gen_bits[i]) queue_word(OP_CLEAR, i[POS_W-1:0]);
          end
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything offered and answered, then a margin for stray results
    wait (pending_words_q.size() == 0 && !in_valid_i && owed_results_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // sender: one word at a time, a random gap after each, with stretches
  // where words follow back to back
  always @(posedge clk_i) begin : drive_words
    bitmap_req_t w;
    int unsigned gap;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      send_wait   <= 0;
      words_sent  <= 0;
      send_steady <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_map_op(opcode_i, position_i);
        words_sent <= words_sent + 1;
        if (words_sent % 100 == 99) send_steady <= !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 7);
        if (gap == 0 && pending_words_q.size() != 0) begin
          w = pending_words_q.pop_front();
          opcode_i   <= w.op;
          position_i <= w.pos;
        end else begin
          in_valid_i <= 1'b0;
          send_wait  <= gap;
        end
      end else if (!in_valid_i) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
        end else if (pending_words_q.size() != 0) begin
          w = pending_words_q.pop_front();
          opcode_i   <= w.op;
          position_i <= w.pos;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // receiver: checks each word against the oldest owed answer and stalls
  // at random after it; ready is held low during the long hold-off
  always @(posedge clk_i) begin : watch_results
    bitmap_result_t owed;
    int unsigned stall;
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      recv_wait    <= 0;
      results_seen <= 0;
      mismatches   <= 0;
      recv_steady  <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (results_seen % 128 == 127) recv_steady <= !recv_steady;
        if (owed_results_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("unexpected result: bit %0d count %0d first %0d empty %0d",
                     bit_value_o, ones_count_o, first_set_o, map_empty_o);
          end
        end else begin
          owed = owed_results_q.pop_front();
          if (bit_value_o !== owed.bit_value || ones_count_o !== owed.ones_count ||
              first_set_o !== owed.first_set || map_empty_o !== owed.map_empty) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("result %0d: bit %0d/%0d count %0d/%0d first %0d/%0d empty %0d/%0d",
                       results_seen, owed.bit_value, bit_value_o, owed.ones_count,
                       ones_count_o, owed.first_set, first_set_o, owed.map_empty,
                       map_empty_o);
            end
          end
        end
        stall = recv_steady ? 0 : $urandom_range(0, 7);
        recv_wait   <= stall;
        out_ready_i <= (stall == 0) && (hold_cnt == 0);
      end else if (recv_wait != 0) begin
        recv_wait   <= recv_wait - 1;
        out_ready_i <= (recv_wait == 1) && (hold_cnt == 0);
      end else begin
        out_ready_i <= (hold_cnt == 0);
      end
    end
  end

  // one long hold-off on the result side so the output register fills and
  // the block has to back-pressure the sender
  always @(posedge clk_i) begin : hold_results
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // watchdog: too long without a word moving on either side ends the run
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bscf_pkg.sv
hw/rtl/bscf_store.sv
hw/rtl/bscf_ffs.sv
hw/rtl/bitmap_set_clear_count_find_first.sv
bench/bitmap_set_clear_count_find_first_tb.sv
